### design/bounded_linked_deque_core_macros.svh
// Assertion macros shared by the deque RTL.
// Depends on the including module having signals named clock and reset.
`ifndef BOUNDED_LINKED_DEQUE_CORE_MACROS_SVH
`define BOUNDED_LINKED_DEQUE_CORE_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define BLD_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Checks that a consequent holds whenever an antecedent holds.
`define BLD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### design/bld_pkg.sv
// Package for the bounded linked deque: sizes, operation and status codes, command type.
// Used by every module of the block; depends on nothing.
package bld_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int PTR_W = IDX_W + 1;
   localparam int KIND_W = 3;
   localparam int VALUE_W = 16;
   localparam int TOTAL_W = 7;
   localparam int STATUS_W = 2;
   localparam int QUEUE_AW = 1;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [PTR_W-1:0] ptr_type;

   localparam ptr_type NULL_SLOT = PTR_W'(DEPTH);

   typedef enum logic [KIND_W-1:0] {
      OP_ADD_FRONT    = 3'd0,
      OP_ADD_BACK     = 3'd1,
      OP_REMOVE_VALUE = 3'd2,
      OP_REMOVE_FRONT = 3'd3,
      OP_REMOVE_BACK  = 3'd4,
      OP_CONTAINS     = 3'd5,
      OP_COUNT        = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_LINK,
      ST_NEIGH,
      ST_WALK,
      ST_UNLINK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

### design/bld_front.sv
// Front stage of the deque: accepts items and classifies their kind into an operation.
// Depends on bld_pkg.
module bld_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bld_pkg::VALUE_W-1:0] req_tdata,  // value
   input  logic [bld_pkg::KIND_W-1:0]  req_tuser,  // kind
   output logic                        cmd_valid,
   input  logic                        cmd_ready,
   output bld_pkg::cmd_type            cmd
);

   logic             valid_ff, valid_in;
   bld_pkg::cmd_type cmd_ff, cmd_in;
   bld_pkg::op_type  op_dec;

   always_comb begin
      case (req_tuser)
         bld_pkg::OP_ADD_FRONT:    op_dec = bld_pkg::OP_ADD_FRONT;
         bld_pkg::OP_ADD_BACK:     op_dec = bld_pkg::OP_ADD_BACK;
         bld_pkg::OP_REMOVE_VALUE: op_dec = bld_pkg::OP_REMOVE_VALUE;
         bld_pkg::OP_REMOVE_FRONT: op_dec = bld_pkg::OP_REMOVE_FRONT;
         bld_pkg::OP_REMOVE_BACK:  op_dec = bld_pkg::OP_REMOVE_BACK;
         bld_pkg::OP_CONTAINS:     op_dec = bld_pkg::OP_CONTAINS;
         default:                  op_dec = bld_pkg::OP_COUNT;
      endcase
   end

   assign req_tready = !valid_ff || cmd_ready;

   always_comb begin
      cmd_in = cmd_ff;
      valid_in = valid_ff && !cmd_ready;
      if (req_tvalid && req_tready) begin
         cmd_in.op = op_dec;
         cmd_in.value = req_tdata;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd = cmd_ff;

endmodule

### design/bld_queue.sv
// Short command queue between the front stage and the list engine.
// Depends on bld_pkg.
module bld_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bld_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output bld_pkg::cmd_type out_cmd
);

   bld_pkg::cmd_type                 mem_ff [bld_pkg::QUEUE_DEPTH];
   logic [bld_pkg::QUEUE_AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [bld_pkg::QUEUE_AW:0]       cnt_ff, cnt_in;
   logic                             push, pop;

   assign in_ready = cnt_ff != (bld_pkg::QUEUE_AW+1)'(bld_pkg::QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign out_cmd = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_cmd;
      end
   end

endmodule

### design/bld_back.sv
// List engine of the deque: slot memories, free-slot stack, list walk and result register.
// Depends on bld_pkg and bounded_linked_deque_core_macros.svh.
`include "bounded_linked_deque_core_macros.svh"

module bld_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  bld_pkg::cmd_type             cmd,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,  // removed_value, found, entry_total
   output logic [bld_pkg::STATUS_W-1:0] rsp_tuser   // status
);

   logic signed [bld_pkg::VALUE_W-1:0] value_mem [bld_pkg::DEPTH];
   bld_pkg::ptr_type                   next_mem  [bld_pkg::DEPTH];
   bld_pkg::ptr_type                   prev_mem  [bld_pkg::DEPTH];
   bld_pkg::idx_type                   free_mem  [bld_pkg::DEPTH];

   bld_pkg::state_type state_ff, state_in;
   bld_pkg::op_type    op_ff, op_in;
   logic signed [bld_pkg::VALUE_W-1:0] value_ff, value_in;
   bld_pkg::idx_type   slot_ff, slot_in;
   bld_pkg::ptr_type   nb_ff, nb_in;
   bld_pkg::ptr_type   first_ff, first_in, last_ff, last_in;
   bld_pkg::ptr_type   count_ff, count_in, free_cnt_ff, free_cnt_in, fresh_ff, fresh_in;
   logic               found_ff, found_in;
   bld_pkg::status_type status_ff, status_in;
   logic signed [bld_pkg::VALUE_W-1:0] removed_ff, removed_in;

   bld_pkg::idx_type   rd_addr;
   logic signed [bld_pkg::VALUE_W-1:0] value_rd_ff;
   bld_pkg::ptr_type   next_rd_ff, prev_rd_ff;
   bld_pkg::idx_type   free_rd_ff;

   logic               value_we, next_we, prev_we, free_we;
   bld_pkg::idx_type   next_wa, prev_wa;
   bld_pkg::ptr_type   next_wd, prev_wd;

   logic               rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [23:0]        rsp_data_ff;
   bld_pkg::status_type rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      value_in = value_ff;
      slot_in = slot_ff;
      nb_in = nb_ff;
      first_in = first_ff;
      last_in = last_ff;
      count_in = count_ff;
      free_cnt_in = free_cnt_ff;
      fresh_in = fresh_ff;
      found_in = found_ff;
      status_in = status_ff;
      removed_in = removed_ff;
      rd_addr = slot_ff;
      cmd_ready = 1'b0;
      value_we = 1'b0;
      next_we = 1'b0;
      prev_we = 1'b0;
      free_we = 1'b0;
      next_wa = slot_ff;
      prev_wa = slot_ff;
      next_wd = bld_pkg::NULL_SLOT;
      prev_wd = bld_pkg::NULL_SLOT;
      rsp_load = 1'b0;
      case (state_ff)
         bld_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               op_in = cmd.op;
               value_in = cmd.value;
               found_in = 1'b0;
               status_in = bld_pkg::STATUS_DONE;
               removed_in = '0;
               case (cmd.op)
                  bld_pkg::OP_ADD_FRONT, bld_pkg::OP_ADD_BACK: begin
                     if (count_ff == bld_pkg::NULL_SLOT) begin
                        status_in = bld_pkg::STATUS_FULL;
                        state_in = bld_pkg::ST_RESULT;
                     end else begin
                        state_in = bld_pkg::ST_ALLOC;
                     end
                  end
                  bld_pkg::OP_REMOVE_FRONT: begin
                     if (first_ff >= bld_pkg::NULL_SLOT) begin
                        status_in = bld_pkg::STATUS_EMPTY;
                        state_in = bld_pkg::ST_RESULT;
                     end else begin
                        rd_addr = first_ff[bld_pkg::IDX_W-1:0];
                        slot_in = first_ff[bld_pkg::IDX_W-1:0];
                        state_in = bld_pkg::ST_UNLINK;
                     end
                  end
                  bld_pkg::OP_REMOVE_BACK: begin
                     if (last_ff >= bld_pkg::NULL_SLOT) begin
                        status_in = bld_pkg::STATUS_EMPTY;
                        state_in = bld_pkg::ST_RESULT;
                     end else begin
                        rd_addr = last_ff[bld_pkg::IDX_W-1:0];
                        slot_in = last_ff[bld_pkg::IDX_W-1:0];
                        state_in = bld_pkg::ST_UNLINK;
                     end
                  end
                  bld_pkg::OP_REMOVE_VALUE, bld_pkg::OP_CONTAINS: begin
                     if (first_ff >= bld_pkg::NULL_SLOT) begin
                        status_in = (cmd.op == bld_pkg::OP_REMOVE_VALUE) ?
                                    bld_pkg::STATUS_EMPTY : bld_pkg::STATUS_DONE;
                        state_in = bld_pkg::ST_RESULT;
                     end else begin
                        rd_addr = first_ff[bld_pkg::IDX_W-1:0];
                        slot_in = first_ff[bld_pkg::IDX_W-1:0];
                        state_in = bld_pkg::ST_WALK;
                     end
                  end
                  default: begin
                     state_in = bld_pkg::ST_RESULT;
                  end
               endcase
            end
         end
         bld_pkg::ST_ALLOC: begin
            if (free_cnt_ff != '0) begin
               slot_in = free_rd_ff;
               free_cnt_in = free_cnt_ff - 1'b1;
            end else begin
               slot_in = fresh_ff[bld_pkg::IDX_W-1:0];
               fresh_in = fresh_ff + 1'b1;
            end
            state_in = bld_pkg::ST_LINK;
         end
         bld_pkg::ST_LINK: begin
            value_we = 1'b1;
            next_we = 1'b1;
            prev_we = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = bld_pkg::ST_NEIGH;
            if (op_ff == bld_pkg::OP_ADD_FRONT) begin
               next_wd = first_ff;
               nb_in = first_ff;
               first_in = {1'b0, slot_ff};
               if (first_ff >= bld_pkg::NULL_SLOT) begin
                  last_in = {1'b0, slot_ff};
                  state_in = bld_pkg::ST_RESULT;
               end
            end else begin
               prev_wd = last_ff;
               nb_in = last_ff;
               last_in = {1'b0, slot_ff};
               if (last_ff >= bld_pkg::NULL_SLOT) begin
                  first_in = {1'b0, slot_ff};
                  state_in = bld_pkg::ST_RESULT;
               end
            end
         end
         bld_pkg::ST_NEIGH: begin
            if (op_ff == bld_pkg::OP_ADD_FRONT) begin
               prev_we = 1'b1;
               prev_wa = nb_ff[bld_pkg::IDX_W-1:0];
               prev_wd = {1'b0, slot_ff};
            end else begin
               next_we = 1'b1;
               next_wa = nb_ff[bld_pkg::IDX_W-1:0];
               next_wd = {1'b0, slot_ff};
            end
            state_in = bld_pkg::ST_RESULT;
         end
         bld_pkg::ST_WALK: begin
            if (value_rd_ff == value_ff) begin
               found_in = 1'b1;
               state_in = (op_ff == bld_pkg::OP_CONTAINS) ?
                          bld_pkg::ST_RESULT : bld_pkg::ST_UNLINK;
            end else if (next_rd_ff >= bld_pkg::NULL_SLOT) begin
               status_in = (op_ff == bld_pkg::OP_REMOVE_VALUE) ?
                           bld_pkg::STATUS_EMPTY : bld_pkg::STATUS_DONE;
               state_in = bld_pkg::ST_RESULT;
            end else begin
               rd_addr = next_rd_ff[bld_pkg::IDX_W-1:0];
               slot_in = next_rd_ff[bld_pkg::IDX_W-1:0];
            end
         end
         bld_pkg::ST_UNLINK: begin
            if (prev_rd_ff < bld_pkg::NULL_SLOT) begin
               next_we = 1'b1;
               next_wa = prev_rd_ff[bld_pkg::IDX_W-1:0];
               next_wd = next_rd_ff;
            end else begin
               first_in = next_rd_ff;
            end
            if (next_rd_ff < bld_pkg::NULL_SLOT) begin
               prev_we = 1'b1;
               prev_wa = next_rd_ff[bld_pkg::IDX_W-1:0];
               prev_wd = prev_rd_ff;
            end else begin
               last_in = prev_rd_ff;
            end
            free_we = 1'b1;
            free_cnt_in = free_cnt_ff + 1'b1;
            count_in = count_ff - 1'b1;
            if (op_ff != bld_pkg::OP_REMOVE_VALUE) begin
               removed_in = value_rd_ff;
            end
            state_in = bld_pkg::ST_RESULT;
         end
         bld_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = bld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bld_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bld_pkg::ST_IDLE;
         first_ff <= bld_pkg::NULL_SLOT;
         last_ff <= bld_pkg::NULL_SLOT;
         count_ff <= '0;
         free_cnt_ff <= '0;
         fresh_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         last_ff <= last_in;
         count_ff <= count_in;
         free_cnt_ff <= free_cnt_in;
         fresh_ff <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      value_ff <= value_in;
      slot_ff <= slot_in;
      nb_ff <= nb_in;
      found_ff <= found_in;
      status_ff <= status_in;
      removed_ff <= removed_in;
      if (rsp_load) begin
         rsp_data_ff <= {bld_pkg::TOTAL_W'(count_ff), found_ff, removed_ff};
         rsp_status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[slot_ff] <= value_ff;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (free_we) begin
         free_mem[free_cnt_ff[bld_pkg::IDX_W-1:0]] <= slot_ff;
      end
      value_rd_ff <= value_mem[rd_addr];
      next_rd_ff <= next_mem[rd_addr];
      prev_rd_ff <= prev_mem[rd_addr];
      free_rd_ff <= free_mem[bld_pkg::IDX_W'(free_cnt_ff - 1'b1)];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;

   `BLD_ASSERT_ALWAYS(a_count_bound, count_ff <= bld_pkg::NULL_SLOT, "entry count above depth")
   `BLD_ASSERT_IMPLY(a_slot_balance, state_ff == bld_pkg::ST_IDLE, count_ff == fresh_ff - free_cnt_ff, "slot accounting lost a slot")
   `BLD_ASSERT_IMPLY(a_empty_links, state_ff == bld_pkg::ST_IDLE, (first_ff >= bld_pkg::NULL_SLOT) == (count_ff == '0) && (last_ff >= bld_pkg::NULL_SLOT) == (count_ff == '0), "list ends disagree with count")

endmodule

### design/bounded_linked_deque_core.sv
// Top level of the bounded linked deque: front stage, command queue and list engine.
// Depends on bld_pkg, bld_front, bld_queue and bld_back.
//
// A bounded doubly linked list of up to 64 signed 16-bit values; each item is one
// operation and gives exactly one result item. In the list engine an add steps through
// ALLOC, LINK and NEIGH (NEIGH skipped on an empty list), remove front or back through
// UNLINK, and the count query goes straight to RESULT. Remove value and contains walk
// the list one linked slot per cycle through the slot memories' single read port, and
// remove value then unlinks the match; a miss walks every entry. The front register,
// the queue and the result register lie between request and result, and a result
// that waits stalls the engine. The front stage and a two-item queue keep accepting
// items while the engine is busy, as long as they have room.
module bounded_linked_deque_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bld_pkg::VALUE_W-1:0]  req_tdata,  // value
   input  logic [bld_pkg::KIND_W-1:0]   req_tuser,  // kind
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,  // removed_value, found, entry_total
   output logic [bld_pkg::STATUS_W-1:0] rsp_tuser   // status
);

   logic             front_valid, front_ready, queue_valid, queue_ready;
   bld_pkg::cmd_type front_cmd, queue_cmd;

   bld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   bld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   bld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/tb.sv
// Self-checking testbench for bounded_linked_deque_core: directed and random deque operations.
// Depends on bld_pkg and the RTL; keeps its own linked-list predictor and checks every result.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [15:0] removed;
      logic        found;
      logic [6:0]  total;
      logic [1:0]  status;
   } outcome_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   bounded_linked_deque_core i_dut (.*);

   always #10 clock = ~clock;

   // The predicted list, front at index 0.
   logic signed [15:0] list_model[$];
   outcome_type pending_outcomes[$];
   int errors = 0;
   int sent = 0;
   int checked = 0;
   int idle_cycles = 0;
   int hold_off = 0;
   bit stall_rx = 0;
   int n_full = 0, n_empty = 0, n_found = 0;

   function automatic outcome_type predict_op(logic [2:0] kind, logic signed [15:0] v);
      outcome_type o;
      int pos;
      o = '{16'd0, 1'b0, 7'd0, bld_pkg::STATUS_DONE};
      pos = -1;
      if (kind == bld_pkg::OP_REMOVE_VALUE || kind == bld_pkg::OP_CONTAINS) begin
         foreach (list_model[i]) begin
            if (pos < 0 && list_model[i] == v) pos = i;
         end
      end
      case (kind)
         bld_pkg::OP_ADD_FRONT, bld_pkg::OP_ADD_BACK: begin
            if (list_model.size() >= bld_pkg::DEPTH) o.status = bld_pkg::STATUS_FULL;
            else if (kind == bld_pkg::OP_ADD_FRONT) list_model.push_front(v);
            else list_model.push_back(v);
         end
         bld_pkg::OP_REMOVE_VALUE: begin
            if (pos >= 0) begin
               list_model.delete(pos);
               o.found = 1;
            end else o.status = bld_pkg::STATUS_EMPTY;
         end
         bld_pkg::OP_REMOVE_FRONT, bld_pkg::OP_REMOVE_BACK: begin
            if (list_model.size() == 0) o.status = bld_pkg::STATUS_EMPTY;
            else if (kind == bld_pkg::OP_REMOVE_FRONT) o.removed = list_model.pop_front();
            else o.removed = list_model.pop_back();
         end
         bld_pkg::OP_CONTAINS: o.found = (pos >= 0);
         default: ;
      endcase
      o.total = 7'(list_model.size());
      return o;
   endfunction

   // The valid stays high when the next item follows with no gap.
   task automatic send_item(logic [2:0] kind, logic signed [15:0] v, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= v;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes.push_back(predict_op(kind, v));
      sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall per item, or a long hold-off when asked.
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_tready <= 0;
            hold_off--;
         end else if (!rsp_tready) begin
            rsp_tready <= 1;
         end else if (rsp_tvalid) begin
            gap = stall_rx ? $urandom_range(0, 19) : 0;
            if (gap > 0) begin
               rsp_tready <= 0;
               repeat (gap - 1) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result item %h status %0d", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            e = pending_outcomes.pop_front();
            checked++;
            if (rsp_tuser == bld_pkg::STATUS_FULL) n_full++;
            if (rsp_tuser == bld_pkg::STATUS_EMPTY) n_empty++;
            if (rsp_tdata[16]) n_found++;
            if (rsp_tdata[15:0] !== e.removed) begin
               $error("removed_value expected %0h actual %0h", e.removed, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[16] !== e.found) begin
               $error("found expected %0d actual %0d", e.found, rsp_tdata[16]);
               errors++;
            end
            if (rsp_tdata[23:17] !== e.total) begin
               $error("entry_total expected %0d actual %0d", e.total, rsp_tdata[23:17]);
               errors++;
            end
            if (rsp_tuser !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_off > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Timeout with %0d results outstanding", pending_outcomes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic signed [15:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return 16'($urandom_range(0, 15));
      if (r == 7) return 16'h8000;
      if (r == 8) return 16'h7FFF;
      return 16'($urandom);
   endfunction

   task automatic test_extremes();
      send_item(bld_pkg::OP_REMOVE_FRONT, 16'sd5);
      send_item(bld_pkg::OP_REMOVE_BACK, -16'sd1);
      send_item(bld_pkg::OP_REMOVE_VALUE, 16'sd3);
      send_item(bld_pkg::OP_CONTAINS, 16'sd3);
      send_item(bld_pkg::OP_COUNT, 16'sd0);
      send_item(bld_pkg::OP_ADD_FRONT, 16'h8000);
      send_item(bld_pkg::OP_ADD_BACK, 16'h7FFF);
      send_item(bld_pkg::OP_ADD_FRONT, 16'hFFFF);
      send_item(bld_pkg::OP_ADD_BACK, 16'h0000);
      send_item(bld_pkg::OP_ADD_BACK, 16'h5555);
      send_item(bld_pkg::OP_ADD_BACK, 16'hAAAA);
      send_item(bld_pkg::OP_CONTAINS, 16'h7FFF);
      send_item(bld_pkg::OP_CONTAINS, 16'h1234);
      send_item(bld_pkg::OP_REMOVE_VALUE, 16'h7FFF);
      send_item(bld_pkg::OP_REMOVE_VALUE, 16'h7FFF);
      send_item(3'd7, 16'h1111);
      send_item(bld_pkg::OP_REMOVE_FRONT, 16'h0);
      send_item(bld_pkg::OP_REMOVE_BACK, 16'h0);
      send_item(bld_pkg::OP_COUNT, 16'h0);
      wait_drained();
   endtask

   // Fill past capacity while the receiver holds off, then drain it empty.
   task automatic test_full_and_backpressure();
      hold_off = 300;
      for (int i = 0; i < bld_pkg::DEPTH + 4; i++)
         send_item(i % 2 ? bld_pkg::OP_ADD_BACK : bld_pkg::OP_ADD_FRONT, 16'(i), 0);
      send_item(bld_pkg::OP_CONTAINS, 16'sd1);
      send_item(bld_pkg::OP_CONTAINS, 16'sd999);
      send_item(bld_pkg::OP_REMOVE_VALUE, 16'sd999);
      wait_drained();
      for (int i = 0; i < bld_pkg::DEPTH + 2; i++)
         send_item($urandom_range(0, 1) ? bld_pkg::OP_REMOVE_FRONT : bld_pkg::OP_REMOVE_BACK,
                   16'(i));
      wait_drained();
   endtask

   task automatic test_random(int count);
      int r;
      logic [2:0] kind;
      for (int i = 0; i < count; i++) begin
         stall_rx = (i / 150) % 3 != 0;
         r = $urandom_range(0, 99);
         if (list_model.size() < 8) kind = r < 60 ? 3'(r % 2) : 3'($urandom_range(0, 7));
         else if (list_model.size() > 56) kind = r < 50 ? 3'($urandom_range(2, 4))
                                                        : 3'($urandom_range(0, 7));
         else kind = 3'($urandom_range(0, 7));
         send_item(kind, pick_value(), (i / 100) % 4 != 0);
         if (i == count / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      stall_rx = 1;
      test_extremes();
      test_full_and_backpressure();
      test_random(1050);
      wait_drained();
      repeat (100) @(posedge clock);
      $display("Sent %0d items, checked %0d results: %0d full drops, %0d empty or missing,",
               sent, checked, n_full, n_empty);
      $display("%0d searches hit; long hold-off and a full list were exercised.", n_found);
      if (errors == 0 && pending_outcomes.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

### bounded_linked_deque_core.f
+incdir+design
design/bld_pkg.sv
design/bld_front.sv
design/bld_queue.sv
design/bld_back.sv
design/bounded_linked_deque_core.sv
bench/tb.sv
